// ===== src/fpmr_pkg.sv =====
// shared constants and types for the frame pixel mean and rms block
package fpmr_pkg;

   // default capacity of the pixel store and of the frame count
   localparam int unsigned DEF_MAX_PIXELS = 65536;
   localparam int unsigned DEF_MAX_FRAMES = 65535;

   // field widths
   localparam int unsigned PIXEL_W     = 17;
   localparam int unsigned INDEX_W     = 16;
   localparam int unsigned SUM_W       = 34;
   localparam int unsigned SQ_W        = 48;
   localparam int unsigned NFR_W       = 16;
   localparam int unsigned FPIX_W      = 17;
   localparam int unsigned MEAN_W      = 25;
   localparam int unsigned RMS_W       = 24;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 17;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PIXELS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_TO_AVG = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPUTE_RMS   = 2'd2;

   // one pixel of the last frame, handed from front to back
   typedef struct packed {
      logic [INDEX_W-1:0]      idx;
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         sq;
      logic [NFR_W-1:0]        nfr;
      logic                    rms_en;
      logic                    last_pix;
   } work_item_type;

endpackage

// ===== src/fpmr_front.sv =====
// front end: csr registers, pixel counters and read-modify-write of the pixel store
module fpmr_front #(
   parameter int unsigned MAX_PIXELS = fpmr_pkg::DEF_MAX_PIXELS,
   parameter int unsigned MAX_FRAMES = fpmr_pkg::DEF_MAX_FRAMES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   input  logic signed [fpmr_pkg::PIXEL_W-1:0]    req_pixel_value,
   output logic                                   req_full,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fpmr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fpmr_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                   q_push,
   output fpmr_pkg::work_item_type                q_item,
   input  logic                                   q_full
);
   import fpmr_pkg::*;

   localparam int unsigned IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int unsigned FRM_W = $clog2(MAX_FRAMES + 1);

   // csr registers
   logic [FPIX_W-1:0] fpix_ff, fpix_in;
   logic [NFR_W-1:0]  nfr_cfg_ff, nfr_cfg_in;
   logic              rms_cfg_ff, rms_cfg_in;

   // counters and registered read-modify-write stage
   logic [IDX_W-1:0]  pix_cnt_ff, pix_cnt_in;
   logic [FRM_W-1:0]  frm_cnt_ff, frm_cnt_in;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic signed [PIXEL_W-1:0] val_ff, val_in;
   logic              first_ff, first_in;
   logic              lastf_ff, lastf_in;
   logic              lastp_ff, lastp_in;
   logic [NFR_W-1:0]  nfr_ff, nfr_in;
   logic              rms_ff, rms_in;

   // pixel store
   logic [SUM_W-1:0]  sum_mem [MAX_PIXELS];
   logic [SQ_W-1:0]   sq_mem [MAX_PIXELS];
   logic [SUM_W-1:0]  sum_rd_ff;
   logic [SQ_W-1:0]   sq_rd_ff;

   logic              accept;
   logic [31:0]       npix, nfr_clamp, idx_wide;
   logic [NFR_W-1:0]  nfr_eff;
   logic              last_pix, last_frame;
   logic signed [SUM_W-1:0] sq_prod;
   logic [SUM_W-1:0]  val_ext, new_sum;
   logic [SQ_W-1:0]   new_sq;

   assign csr_ready = 1'b1;
   assign req_full  = busy_ff || q_full;
   assign accept    = req_push && !req_full;

   // clamp the csr values into their legal ranges
   always_comb begin
      if (fpix_ff == '0) begin
         npix = 32'd1;
      end else if (32'(fpix_ff) > MAX_PIXELS) begin
         npix = 32'(MAX_PIXELS);
      end else begin
         npix = 32'(fpix_ff);
      end
      if (nfr_cfg_ff == '0) begin
         nfr_clamp = 32'd1;
      end else if (32'(nfr_cfg_ff) > MAX_FRAMES) begin
         nfr_clamp = 32'(MAX_FRAMES);
      end else begin
         nfr_clamp = 32'(nfr_cfg_ff);
      end
      nfr_eff    = nfr_clamp[NFR_W-1:0];
      last_pix   = (32'(pix_cnt_ff) + 32'd1) >= npix;
      last_frame = (32'(frm_cnt_ff) + 32'd1) >= nfr_clamp;
   end

   // csr writes and counter advance
   always_comb begin
      fpix_in    = fpix_ff;
      nfr_cfg_in = nfr_cfg_ff;
      rms_cfg_in = rms_cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_PIXELS:  fpix_in    = csr_wdata;
            CSR_FRAMES_TO_AVG: nfr_cfg_in = csr_wdata[NFR_W-1:0];
            CSR_COMPUTE_RMS:   rms_cfg_in = csr_wdata[0];
            default: ;
         endcase
      end
      pix_cnt_in = pix_cnt_ff;
      frm_cnt_in = frm_cnt_ff;
      busy_in    = 1'b0;
      idx_in     = idx_ff;
      val_in     = val_ff;
      first_in   = first_ff;
      lastf_in   = lastf_ff;
      lastp_in   = lastp_ff;
      nfr_in     = nfr_ff;
      rms_in     = rms_ff;
      if (accept) begin
         busy_in  = 1'b1;
         idx_in   = pix_cnt_ff;
         val_in   = req_pixel_value;
         first_in = (frm_cnt_ff == '0);
         lastf_in = last_frame;
         lastp_in = last_pix;
         nfr_in   = nfr_eff;
         rms_in   = rms_cfg_ff;
         if (last_pix) begin
            pix_cnt_in = '0;
            frm_cnt_in = last_frame ? '0 : frm_cnt_ff + 1'b1;
         end else begin
            pix_cnt_in = pix_cnt_ff + 1'b1;
         end
      end
   end

   // accumulate the sample into the read entry
   always_comb begin
      sq_prod  = val_ff * val_ff;
      val_ext  = {{(SUM_W-PIXEL_W){val_ff[PIXEL_W-1]}}, val_ff};
      new_sum  = first_ff ? val_ext : sum_rd_ff + val_ext;
      new_sq   = first_ff ? {{(SQ_W-SUM_W){1'b0}}, sq_prod}
                          : sq_rd_ff + {{(SQ_W-SUM_W){1'b0}}, sq_prod};
      idx_wide = 32'(idx_ff);
   end

   assign q_push          = busy_ff && lastf_ff;
   assign q_item.idx      = idx_wide[INDEX_W-1:0];
   assign q_item.sum      = new_sum;
   assign q_item.sq       = new_sq;
   assign q_item.nfr      = nfr_ff;
   assign q_item.rms_en   = rms_ff;
   assign q_item.last_pix = lastp_ff;

   // pixel store ports
   always_ff @(posedge clock) begin
      if (accept) begin
         sum_rd_ff <= sum_mem[pix_cnt_ff];
         sq_rd_ff  <= sq_mem[pix_cnt_ff];
      end
      if (busy_ff) begin
         sum_mem[idx_ff] <= new_sum;
         if (rms_ff) begin
            sq_mem[idx_ff] <= new_sq;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fpix_ff    <= 17'h10000;
         nfr_cfg_ff <= 16'd100;
         rms_cfg_ff <= 1'b0;
         pix_cnt_ff <= '0;
         frm_cnt_ff <= '0;
         busy_ff    <= 1'b0;
      end else begin
         fpix_ff    <= fpix_in;
         nfr_cfg_ff <= nfr_cfg_in;
         rms_cfg_ff <= rms_cfg_in;
         pix_cnt_ff <= pix_cnt_in;
         frm_cnt_ff <= frm_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      first_ff <= first_in;
      lastf_ff <= lastf_in;
      lastp_ff <= lastp_in;
      nfr_ff   <= nfr_in;
      rms_ff   <= rms_in;
   end

endmodule

// ===== src/fpmr_queue.sv =====
// two-entry queue of finished pixel sums between front and back
module fpmr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fpmr_pkg::work_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output fpmr_pkg::work_item_type head_item,
   output logic                    empty
);
   import fpmr_pkg::*;

   work_item_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/fpmr_back.sv =====
// back end: serial divide, multiply and square root that turn sums into mean and rms
module fpmr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  fpmr_pkg::work_item_type            q_item,
   output logic                               q_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [fpmr_pkg::INDEX_W-1:0]       rsp_pixel_index,
   output logic signed [fpmr_pkg::MEAN_W-1:0] rsp_mean_value,
   output logic [fpmr_pkg::RMS_W-1:0]         rsp_rms_value,
   output logic                               rsp_last_pixel
);
   import fpmr_pkg::*;

   localparam int unsigned NUM_W  = SUM_W + 8;
   localparam int unsigned ROOT_W = 40;
   localparam int unsigned RAD_W  = 2 * ROOT_W;
   localparam int unsigned SREM_W = ROOT_W + 3;
   localparam int unsigned PACC_W = 64;
   localparam int unsigned MACC_W = 68;
   localparam int unsigned HALF_W = SUM_W / 2;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DIV_MEAN = 9'b000000010,
      ST_MEAN_FIX = 9'b000000100,
      ST_MUL      = 9'b000001000,
      ST_DIFF     = 9'b000010000,
      ST_SQRT     = 9'b000100000,
      ST_DIV_RMS  = 9'b001000000,
      ST_RMS_FIX  = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic               neg_ff, neg_in;
   logic [SUM_W-1:0]   mag_ff, mag_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [NFR_W-1:0]   nfr_ff, nfr_in;
   logic               rms_en_ff, rms_en_in;
   logic               lastp_ff, lastp_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NFR_W-1:0]   rem_ff, rem_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [RMS_W-1:0]   rms_ff, rms_in;
   logic [47:0]        prod_ff, prod_in;
   logic [PACC_W-1:0]  pacc_ff, pacc_in;
   logic [MACC_W-1:0]  macc_ff, macc_in;
   logic [2:0]         step_ff, step_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [SREM_W-1:0]  srem_ff, srem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_idx_ff, out_idx_in;
   logic [MEAN_W-1:0]  out_mean_ff, out_mean_in;
   logic [RMS_W-1:0]   out_rms_ff, out_rms_in;
   logic               out_last_ff, out_last_in;

   logic [NFR_W:0]     div_sh, div_sub;
   logic               div_ge;
   logic [NUM_W-1:0]   div_num_nx;
   logic [NFR_W-1:0]   div_rem_nx;
   logic [SREM_W-1:0]  sq_trial, sq_sh;
   logic               sq_ge;
   logic [ROOT_W-1:0]  root_nx;
   logic [23:0]        mul_a, mul_b;
   logic [NUM_W:0]     mq;
   logic [PACC_W-1:0]  diff;
   logic [SUM_W-1:0]   item_sum_u;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_index = out_idx_ff;
   assign rsp_mean_value  = out_mean_ff;
   assign rsp_rms_value   = out_rms_ff;
   assign rsp_last_pixel  = out_last_ff;

   // one restoring division step by the frame count
   always_comb begin
      div_sh     = {rem_ff, num_ff[NUM_W-1]};
      div_ge     = div_sh >= {1'b0, nfr_ff};
      div_sub    = div_sh - {1'b0, nfr_ff};
      div_rem_nx = div_ge ? div_sub[NFR_W-1:0] : div_sh[NFR_W-1:0];
      div_num_nx = {num_ff[NUM_W-2:0], div_ge};
   end

   // one digit of the square root
   always_comb begin
      sq_sh    = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_ge    = sq_sh >= sq_trial;
      root_nx  = {root_ff[ROOT_W-2:0], sq_ge};
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         3'd0: begin
            mul_a = {8'b0, nfr_ff};
            mul_b = sq_ff[23:0];
         end
         3'd1: begin
            mul_a = {8'b0, nfr_ff};
            mul_b = sq_ff[47:24];
         end
         3'd2: begin
            mul_a = {7'b0, mag_ff[HALF_W-1:0]};
            mul_b = {7'b0, mag_ff[HALF_W-1:0]};
         end
         3'd3: begin
            mul_a = {7'b0, mag_ff[SUM_W-1:HALF_W]};
            mul_b = {7'b0, mag_ff[HALF_W-1:0]};
         end
         3'd4: begin
            mul_a = {7'b0, mag_ff[SUM_W-1:HALF_W]};
            mul_b = {7'b0, mag_ff[SUM_W-1:HALF_W]};
         end
         default: ;
      endcase
   end

   always_comb begin
      mq         = {1'b0, num_ff} + {{NUM_W{1'b0}}, (neg_ff && rem_ff != '0)};
      diff       = pacc_ff - macc_ff[PACC_W-1:0];
      item_sum_u = q_item.sum;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      nfr_in       = nfr_ff;
      rms_en_in    = rms_en_ff;
      lastp_in     = lastp_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      mean_in      = mean_ff;
      rms_in       = rms_ff;
      prod_in      = prod_ff;
      pacc_in      = pacc_ff;
      macc_in      = macc_ff;
      step_in      = step_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_idx_in   = out_idx_ff;
      out_mean_in  = out_mean_ff;
      out_rms_in   = out_rms_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               idx_in    = q_item.idx;
               neg_in    = item_sum_u[SUM_W-1];
               mag_in    = item_sum_u[SUM_W-1] ? '0 - item_sum_u : item_sum_u;
               sq_in     = q_item.sq;
               nfr_in    = q_item.nfr;
               rms_en_in = q_item.rms_en;
               lastp_in  = q_item.last_pix;
               num_in    = {(item_sum_u[SUM_W-1] ? '0 - item_sum_u : item_sum_u), 8'b0};
               rem_in    = '0;
               cnt_in    = '0;
               state_in  = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN, ST_DIV_RMS: begin
            num_in = div_num_nx;
            rem_in = div_rem_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NUM_W - 1)) begin
               state_in = (state_ff == ST_DIV_MEAN) ? ST_MEAN_FIX : ST_RMS_FIX;
            end
         end
         ST_MEAN_FIX: begin
            // floor division: round the magnitude up for negative sums, then saturate
            if (!neg_ff) begin
               mean_in = (num_ff > NUM_W'(24'hFFFFFF)) ? 25'h0FFFFFF : {1'b0, num_ff[23:0]};
            end else begin
               mean_in = (mq > (NUM_W+1)'(25'h1000000)) ? 25'h1000000 : 25'd0 - mq[24:0];
            end
            rms_in  = '0;
            pacc_in = '0;
            macc_in = '0;
            step_in = '0;
            state_in = rms_en_ff ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            // n*sq and mag*mag from partial products, one per cycle
            prod_in = mul_a * mul_b;
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: pacc_in = pacc_ff + PACC_W'(prod_ff);
               3'd2: pacc_in = pacc_ff + PACC_W'({prod_ff, 24'b0});
               3'd3: macc_in = macc_ff + MACC_W'(prod_ff);
               3'd4: macc_in = macc_ff + MACC_W'({prod_ff, 18'b0});
               3'd5: macc_in = macc_ff + MACC_W'({prod_ff, 34'b0});
               default: ;
            endcase
            if (step_ff == 3'd5) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // negative variance clamps to zero
            rad_in   = ({4'b0, pacc_ff} >= macc_ff) ? {diff, 16'b0} : '0;
            srem_in  = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            srem_in = sq_ge ? sq_sh - sq_trial : sq_sh;
            root_in = root_nx;
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROOT_W - 1)) begin
               num_in   = {{(NUM_W-ROOT_W){1'b0}}, root_nx};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV_RMS;
            end
         end
         ST_RMS_FIX: begin
            rms_in   = (num_ff > NUM_W'(24'hFFFFFF)) ? 24'hFFFFFF : num_ff[23:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_idx_in   = idx_ff;
               out_mean_in  = mean_ff;
               out_rms_in   = rms_ff;
               out_last_in  = lastp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      sq_ff       <= sq_in;
      nfr_ff      <= nfr_in;
      rms_en_ff   <= rms_en_in;
      lastp_ff    <= lastp_in;
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      mean_ff     <= mean_in;
      rms_ff      <= rms_in;
      prod_ff     <= prod_in;
      pacc_ff     <= pacc_in;
      macc_ff     <= macc_in;
      step_ff     <= step_in;
      rad_ff      <= rad_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      out_idx_ff  <= out_idx_in;
      out_mean_ff <= out_mean_in;
      out_rms_ff  <= out_rms_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== src/frame_pixel_mean_rms_top.sv =====
// Per-pixel mean and standard deviation over a run of frames. Pixels are pushed in raster
// order; each position keeps a running sum (and a sum of squares when compute_rms is 1) in
// an on-chip store of MAX_PIXELS entries. Every pixel of the last frame of a run produces one
// response with the Q8 mean and Q8 deviation. The front end takes no new pixel while the
// read-modify-write of the single-port pixel store writes back the last one, nor while the
// queue is full. Responses of the last frame are computed by a serial back end: a restoring
// divider gives the mean, and with rms on a shared 24x24 multiplier, a square root and a
// second divide follow. The back end works on one pixel at a time, so during the last frame
// the input is held off once the two-entry queue between the halves fills. The response
// register lets the next response be built while the current one waits. Csr writes take
// effect at once and are meant for idle periods only.
module frame_pixel_mean_rms_top #(
   parameter int unsigned MAX_PIXELS = fpmr_pkg::DEF_MAX_PIXELS,
   parameter int unsigned MAX_FRAMES = fpmr_pkg::DEF_MAX_FRAMES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [fpmr_pkg::PIXEL_W-1:0] req_pixel_value,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [fpmr_pkg::INDEX_W-1:0]        rsp_pixel_index,
   output logic signed [fpmr_pkg::MEAN_W-1:0]  rsp_mean_value,
   output logic [fpmr_pkg::RMS_W-1:0]          rsp_rms_value,
   output logic                                rsp_last_pixel,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpmr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fpmr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fpmr_pkg::*;

   logic          q_push, q_full, q_pop, q_empty;
   work_item_type q_in_item, q_head_item;

   // accumulate stage
   fpmr_front #(
      .MAX_PIXELS(MAX_PIXELS),
      .MAX_FRAMES(MAX_FRAMES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_pixel_value (req_pixel_value),
      .req_full        (req_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_push          (q_push),
      .q_item          (q_in_item),
      .q_full          (q_full)
   );

   // decoupling queue
   fpmr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (q_head_item),
      .empty     (q_empty)
   );

   // statistics stage
   fpmr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (q_head_item),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_rms_value   (rsp_rms_value),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

// ===== dv/frame_pixel_mean_rms_top_test.sv =====
// testbench for the frame pixel mean and rms block: predictor, scoreboard and test tasks
`timescale 1ns / 100ps

module frame_pixel_mean_rms_top_test;
   import fpmr_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned DRAIN_CYCLES = 300;

   // expected response of one pixel of the last frame
   typedef struct {
      logic [INDEX_W-1:0] idx;
      logic [MEAN_W-1:0]  mean;
      logic [RMS_W-1:0]   rms;
      logic               last;
   } pixel_stat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic signed [PIXEL_W-1:0]  req_pixel_value = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [INDEX_W-1:0]         rsp_pixel_index;
   logic signed [MEAN_W-1:0]   rsp_mean_value;
   logic [RMS_W-1:0]           rsp_rms_value;
   logic                       rsp_last_pixel;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // predictor state
   logic [SUM_W-1:0]  sum_store [0:65535];
   logic [SQ_W-1:0]   square_store [0:65535];
   int unsigned       pix_count;
   int unsigned       frame_count;
   logic [FPIX_W-1:0] cfg_frame_pixels;
   logic [NFR_W-1:0]  cfg_frames;
   logic              cfg_rms;

   pixel_stat_type pending_stats[$];
   int unsigned    error_count;
   int unsigned    cycle_count;
   bit             gaps_on;
   bit             rsp_hold;

   frame_pixel_mean_rms_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_pixel_value(req_pixel_value),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_pixel_index(rsp_pixel_index),
      .rsp_mean_value(rsp_mean_value), .rsp_rms_value(rsp_rms_value),
      .rsp_last_pixel(rsp_last_pixel),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("error at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // update the pixel stores and queue the statistics of a last-frame pixel
   task automatic predict_pixel(input logic [PIXEL_W-1:0] raw);
      longint        v, s, mag, mean, n;
      int unsigned   npix, idx;
      bit            first, last_frame, last_pix;
      logic [127:0]  p, qq, d, r, c;
      longint unsigned rms;
      pixel_stat_type st;
      v = longint'($signed(raw));
      npix = cfg_frame_pixels == 0 ? 1 : cfg_frame_pixels;
      if (npix > 65536) npix = 65536;
      n = cfg_frames == 0 ? 1 : cfg_frames;
      idx = pix_count >= 65536 ? 0 : pix_count;
      first = frame_count == 0;
      last_frame = frame_count + 1 >= n;
      last_pix = idx + 1 >= npix;
      if (first) sum_store[idx] = v[SUM_W-1:0];
      else sum_store[idx] = sum_store[idx] + v[SUM_W-1:0];
      if (cfg_rms) begin
         if (first) square_store[idx] = SQ_W'(v * v);
         else square_store[idx] = square_store[idx] + SQ_W'(v * v);
      end
      if (last_frame) begin
         s = longint'($signed(sum_store[idx]));
         mag = s < 0 ? -s : s;
         if (s < 0) mean = -((mag * 256 + n - 1) / n);
         else mean = mag * 256 / n;
         if (mean > 16777215) mean = 16777215;
         if (mean < -16777216) mean = -16777216;
         rms = 0;
         if (cfg_rms) begin
            p = 128'(n) * 128'(square_store[idx]);
            qq = 128'(mag) * 128'(mag);
            if (qq <= p) begin
               d = (p - qq) << 16;
               r = 0;
               for (int b = 43; b >= 0; b--) begin
                  c = r | (128'd1 << b);
                  if (c * c <= d) r = c;
               end
               r = r / 128'(n);
               rms = r > 16777215 ? 16777215 : r[63:0];
            end
         end
         st.idx = idx[INDEX_W-1:0];
         st.mean = mean[MEAN_W-1:0];
         st.rms = rms[RMS_W-1:0];
         st.last = last_pix;
         pending_stats.push_back(st);
      end
      if (last_pix) begin
         pix_count = 0;
         frame_count = last_frame ? 0 : frame_count + 1;
      end else begin
         pix_count = idx + 1;
      end
   endtask

   // push one pixel, with a random gap ahead of it
   task automatic send_pixel(input logic [PIXEL_W-1:0] raw);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel_value <= raw;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      predict_pixel(raw);
   endtask

   // random sample, biased toward the extremes
   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return 17'h10000;
         1: return 17'h0ffff;
         2: return 17'h1ffff;
         default: return PIXEL_W'($urandom_range(0, 131071));
      endcase
   endfunction

   // wait for all responses, then for the back end to settle
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input int unsigned data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data[CSR_DATA_W-1:0];
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      case (index)
         CSR_FRAME_PIXELS:  cfg_frame_pixels = data[FPIX_W-1:0];
         CSR_FRAMES_TO_AVG: cfg_frames = data[NFR_W-1:0];
         CSR_COMPUTE_RMS:   cfg_rms = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned fpix, input int unsigned nfr, input bit rms);
      write_csr(CSR_FRAME_PIXELS, fpix);
      write_csr(CSR_FRAMES_TO_AVG, nfr);
      write_csr(CSR_COMPUTE_RMS, rms);
   endtask

   // response side: random pop gaps, optional long hold
   initial begin
      int unsigned gap;
      pixel_stat_type st;
      @(negedge reset);
      forever begin
         gap = gaps_on ? $urandom_range(0, 3) : 0;
         if (gap > 0 || rsp_hold) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         forever begin
            @(posedge clock);
            if (!rsp_empty) break;
         end
         if (pending_stats.size() == 0) begin
            report_mismatch($sformatf("unexpected response for pixel %0d", rsp_pixel_index));
         end else begin
            st = pending_stats.pop_front();
            if (rsp_pixel_index !== st.idx)
               report_mismatch($sformatf("pixel_index %0d, want %0d", rsp_pixel_index, st.idx));
            if (rsp_mean_value !== st.mean)
               report_mismatch($sformatf("pixel %0d mean %h, want %h",
                                         st.idx, rsp_mean_value, st.mean));
            if (rsp_rms_value !== st.rms)
               report_mismatch($sformatf("pixel %0d rms %h, want %h",
                                         st.idx, rsp_rms_value, st.rms));
            if (rsp_last_pixel !== st.last)
               report_mismatch($sformatf("pixel %0d last_pixel %b, want %b",
                                         st.idx, rsp_last_pixel, st.last));
         end
      end
   end

   // extremes of the sample, with and without rms, negative sums
   task automatic test_directed_extremes();
      logic [PIXEL_W-1:0] vals [8] = '{17'h0, 17'h10000, 17'h0ffff, 17'h1ffff,
                                       17'h1, 17'h0ffff, 17'h10000, 17'h10000};
      configure(4, 2, 1);
      foreach (vals[i]) send_pixel(vals[i]);
      wait_idle();
      write_csr(CSR_COMPUTE_RMS, 0);
      foreach (vals[i]) send_pixel(vals[7 - i]);
      wait_idle();
   endtask

   // zero registers clamp to one, unused index is ignored
   task automatic test_register_clamp();
      configure(0, 0, 1);
      write_csr(CSR_UNUSED, 17'h1ffff);
      repeat (4) send_pixel(rand_pixel());
      wait_idle();
   endtask

   // full-size frame cut short by shrinking frame_pixels mid-frame
   task automatic test_frame_shrink();
      configure(65536, 1, 0);
      repeat (20) send_pixel(rand_pixel());
      wait_idle();
      write_csr(CSR_FRAME_PIXELS, 1);
      repeat (3) send_pixel(rand_pixel());
      wait_idle();
   endtask

   // one pixel averaged over a long run of frames
   task automatic test_long_run();
      gaps_on = 0;
      configure(1, 500, 1);
      repeat (500) send_pixel(rand_pixel());
      wait_idle();
      gaps_on = 1;
   endtask

   // receiver holds off while pixels keep coming, input must back up
   task automatic test_backpressure();
      configure(8, 1, 1);
      rsp_hold = 1;
      fork
         begin
            repeat (3000) @(posedge clock);
            rsp_hold = 0;
         end
         repeat (40) send_pixel(rand_pixel());
      join
      wait_idle();
   endtask

   // random settings, whole runs of random pixels
   task automatic test_random_runs();
      int unsigned fpix, nfr, sent;
      sent = 0;
      while (sent < 1300) begin
         fpix = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(2, 16);
         nfr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 5);
         configure(fpix, nfr, $urandom_range(0, 1));
         gaps_on = $urandom_range(0, 3) != 0;
         if (fpix == 0) fpix = 1;
         if (nfr == 0) nfr = 1;
         repeat ($urandom_range(1, 4) * fpix * nfr) begin
            send_pixel(rand_pixel());
            sent++;
         end
         wait_idle();
      end
      gaps_on = 1;
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      gaps_on = 1;
      rsp_hold = 0;
      pix_count = 0;
      frame_count = 0;
      cfg_frame_pixels = 65536;
      cfg_frames = 100;
      cfg_rms = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_register_clamp();
      test_frame_shrink();
      test_backpressure();
      test_random_runs();
      test_long_run();
      wait_idle();
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== frame_pixel_mean_rms_top.f =====
src/fpmr_pkg.sv
src/fpmr_front.sv
src/fpmr_queue.sv
src/fpmr_back.sv
src/frame_pixel_mean_rms_top.sv
dv/frame_pixel_mean_rms_top_test.sv
